// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lcadc_pkg.sv =====
// shared constants and controller/datapath interface types for the load cell reader
package lcadc_pkg;

   // default geometry of the converter word and the weight fraction
   localparam int DATA_BITS_DEFAULT     = 24;
   localparam int FRACTION_BITS_DEFAULT = 4;

   // divisor width and register reset values
   localparam int DEN_W             = 16;
   localparam int ZERO_OFFSET_RESET = 8671380;
   localparam int SCALE_RESET       = 396;

   // register port geometry
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_INDEX_LSB = 2;

   // register indexes
   typedef logic [0:0] csr_index_type;
   localparam csr_index_type REG_ZERO_OFFSET = 1'b0;
   localparam csr_index_type REG_SCALE       = 1'b1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_tick;   // load a plain tick word into the output register
      logic clk_level;   // clock level of that tick word
      logic shift_en;    // shift the sampled data bit in
      logic shift_clr;   // clear the shift register at the start of a read
      logic diff_load;   // register raw code minus offset
      logic div_init;    // load divider with magnitude and divisor
      logic div_step;    // one restoring division step
      logic finish;      // load the completed sample word
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic div_last;    // current division step is the last one
   } status_type;

endpackage

// ===== src/load_cell_adc_reader.sv =====
// top level of the load cell converter reader
// Master side of a two-wire load cell converter link. Each input word is one
// bit-clock tick with the sampled data level; each output word gives the clock
// level to drive on that tick. After data goes low the block drives
// DATA_BITS+1 pulses, samples DATA_BITS bits MSB first on the low ticks, and on
// the tick that ends the read reports the raw code (top bit flipped) and the
// weight (raw - zero_offset) * 2^FRACTION_BITS / scale_divisor, truncated
// toward zero; a divisor of zero counts as one. A plain tick is loaded straight
// into the output register. The tick that ends a read passes through the offset
// subtract, the divider load, the restoring divider that retires one quotient
// bit per cycle, and the sign step; input is stalled meanwhile.
// A new word is taken in the same cycle the previous output word drains.
// Registers: zero_offset at byte 0, scale_divisor at byte 4.
module load_cell_adc_reader #(
   parameter int DATA_BITS     = lcadc_pkg::DATA_BITS_DEFAULT,
   parameter int FRACTION_BITS = lcadc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   // input channel
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_data_line,
   // result channel
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_clock_line,
   output logic                                    rsp_sample_valid,
   output logic [DATA_BITS-1:0]                    rsp_raw_code,
   output logic signed [DATA_BITS+FRACTION_BITS:0] rsp_weight_q4,
   // register port
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [lcadc_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [lcadc_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [lcadc_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                    csr_pready
);

   lcadc_pkg::cmd_type          cmd;
   lcadc_pkg::status_type       sts;
   logic [DATA_BITS-1:0]        zero_offset;
   logic [lcadc_pkg::DEN_W-1:0] scale_divisor;

   // configuration registers
   lcadc_csr #(
      .DATA_BITS (DATA_BITS)
   ) u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (csr_psel),
      .penable       (csr_penable),
      .pwrite        (csr_pwrite),
      .paddr         (csr_paddr),
      .pwdata        (csr_pwdata),
      .prdata        (csr_prdata),
      .pready        (csr_pready),
      .zero_offset   (zero_offset),
      .scale_divisor (scale_divisor)
   );

   // control
   lcadc_ctrl #(
      .DATA_BITS (DATA_BITS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_line (req_data_line),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .sts           (sts)
   );

   // datapath
   lcadc_dpath #(
      .DATA_BITS     (DATA_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .data_line        (req_data_line),
      .zero_offset      (zero_offset),
      .scale_divisor    (scale_divisor),
      .out_clock_line   (rsp_clock_line),
      .out_sample_valid (rsp_sample_valid),
      .out_raw_code     (rsp_raw_code),
      .out_weight_q4    (rsp_weight_q4)
   );

endmodule

// ===== src/lcadc_csr.sv =====
// register file for zero offset and scale divisor
module lcadc_csr #(
   parameter int DATA_BITS = lcadc_pkg::DATA_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lcadc_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [lcadc_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [lcadc_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready,
   output logic [DATA_BITS-1:0]                zero_offset,
   output logic [lcadc_pkg::DEN_W-1:0]         scale_divisor
);

   logic [DATA_BITS-1:0]        zero_offset_ff, zero_offset_in;
   logic [lcadc_pkg::DEN_W-1:0] scale_ff, scale_in;
   lcadc_pkg::csr_index_type    index;
   logic                        wr_en;

   assign index  = paddr[lcadc_pkg::CSR_INDEX_LSB];
   assign wr_en  = psel & penable & pwrite;
   assign pready = 1'b1;

   // write decode
   always_comb begin
      zero_offset_in = zero_offset_ff;
      scale_in       = scale_ff;
      if (wr_en) begin
         case (index)
            lcadc_pkg::REG_ZERO_OFFSET: zero_offset_in = pwdata[DATA_BITS-1:0];
            lcadc_pkg::REG_SCALE:       scale_in       = pwdata[lcadc_pkg::DEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_offset_ff <= DATA_BITS'(lcadc_pkg::ZERO_OFFSET_RESET);
         scale_ff       <= lcadc_pkg::DEN_W'(lcadc_pkg::SCALE_RESET);
      end else begin
         zero_offset_ff <= zero_offset_in;
         scale_ff       <= scale_in;
      end
   end

   // read mux
   always_comb begin
      case (index)
         lcadc_pkg::REG_ZERO_OFFSET: prdata = lcadc_pkg::CSR_DATA_W'(zero_offset_ff);
         lcadc_pkg::REG_SCALE:       prdata = lcadc_pkg::CSR_DATA_W'(scale_ff);
         default:                    prdata = '0;
      endcase
   end

   assign zero_offset   = zero_offset_ff;
   assign scale_divisor = scale_ff;

endmodule

// ===== src/lcadc_ctrl.sv =====
// controller: link phase, pulse count, divide sequencing and output word valid
module lcadc_ctrl #(
   parameter int DATA_BITS = lcadc_pkg::DATA_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_data_line,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output lcadc_pkg::cmd_type      cmd,
   input  lcadc_pkg::status_type   sts
);

   localparam int PC_W = $clog2(DATA_BITS + 1);
   localparam logic [PC_W-1:0] LAST_PULSE = PC_W'(DATA_BITS);

   typedef enum logic [2:0] {
      PH_WAIT = 3'b001,
      PH_HIGH = 3'b010,
      PH_LOW  = 3'b100
   } phase_type;

   typedef enum logic [3:0] {
      SQ_IDLE = 4'b0001,
      SQ_ABS  = 4'b0010,
      SQ_DIV  = 4'b0100,
      SQ_SIGN = 4'b1000
   } seq_type;

   phase_type       phase_ff, phase_in;
   seq_type         seq_ff, seq_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic            out_valid_ff, out_valid_in;
   logic            accept;

   // busy while dividing, or while the held word is stalled
   assign req_stall = (seq_ff != SQ_IDLE) | (out_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = out_valid_ff;

   // next state and commands
   always_comb begin
      phase_in     = phase_ff;
      seq_in       = seq_ff;
      pc_in        = pc_ff;
      out_valid_in = out_valid_ff & rsp_stall;
      cmd          = '0;
      case (seq_ff)
         SQ_IDLE: begin
            if (accept) begin
               case (phase_ff)
                  PH_HIGH: begin
                     cmd.load_tick = 1'b1;
                     cmd.clk_level = 1'b1;
                     out_valid_in  = 1'b1;
                     phase_in      = PH_LOW;
                  end
                  PH_LOW: begin
                     if (pc_ff == LAST_PULSE) begin
                        // gain pulse done: read completes
                        cmd.diff_load = 1'b1;
                        phase_in      = PH_WAIT;
                        pc_in         = '0;
                        seq_in        = SQ_ABS;
                     end else begin
                        cmd.shift_en  = 1'b1;
                        cmd.load_tick = 1'b1;
                        out_valid_in  = 1'b1;
                        pc_in         = pc_ff + 1'b1;
                        phase_in      = PH_HIGH;
                     end
                  end
                  default: begin
                     // waiting for the converter to pull data low
                     cmd.load_tick = 1'b1;
                     out_valid_in  = 1'b1;
                     phase_in      = PH_WAIT;
                     if (!req_data_line) begin
                        phase_in      = PH_HIGH;
                        pc_in         = '0;
                        cmd.shift_clr = 1'b1;
                     end
                  end
               endcase
            end
         end
         SQ_ABS: begin
            cmd.div_init = 1'b1;
            seq_in       = SQ_DIV;
         end
         SQ_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               seq_in = SQ_SIGN;
            end
         end
         SQ_SIGN: begin
            cmd.finish   = 1'b1;
            out_valid_in = 1'b1;
            seq_in       = SQ_IDLE;
         end
         default: seq_in = SQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         seq_ff       <= SQ_IDLE;
         pc_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         seq_ff       <= seq_in;
         pc_ff        <= pc_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== src/lcadc_dpath.sv =====
// datapath: shift register, offset subtract, restoring divider, output word register
module lcadc_dpath #(
   parameter int DATA_BITS     = lcadc_pkg::DATA_BITS_DEFAULT,
   parameter int FRACTION_BITS = lcadc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  lcadc_pkg::cmd_type                         cmd,
   output lcadc_pkg::status_type                      sts,
   input  logic                                       data_line,
   input  logic [DATA_BITS-1:0]                       zero_offset,
   input  logic [lcadc_pkg::DEN_W-1:0]                scale_divisor,
   output logic                                       out_clock_line,
   output logic                                       out_sample_valid,
   output logic [DATA_BITS-1:0]                       out_raw_code,
   output logic signed [DATA_BITS+FRACTION_BITS:0]    out_weight_q4
);

   localparam int NUM_W    = DATA_BITS + FRACTION_BITS;
   localparam int WEIGHT_W = NUM_W + 1;
   localparam int DEN_W    = lcadc_pkg::DEN_W;
   localparam int REM_W    = DEN_W + 1;
   localparam int CNT_W    = $clog2(NUM_W + 1);
   localparam logic [DATA_BITS-1:0] TOP_BIT = {1'b1, {(DATA_BITS-1){1'b0}}};

   logic [DATA_BITS-1:0] shift_ff, shift_in;
   logic [DATA_BITS:0]   diff_ff, diff_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [NUM_W-1:0]     quo_ff, quo_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 clk_ff, clk_in;
   logic                 smp_ff, smp_in;
   logic [DATA_BITS-1:0] raw_ff, raw_in;
   logic [WEIGHT_W-1:0]  wgt_ff, wgt_in;

   logic [DATA_BITS-1:0] code;
   logic [DATA_BITS:0]   diff_neg;
   logic [DATA_BITS-1:0] mag;
   logic [REM_W-1:0]     rem_shift;
   logic [REM_W:0]       trial;
   logic [WEIGHT_W-1:0]  quo_ext;

   // offset-binary code: top bit flipped
   assign code     = shift_ff ^ TOP_BIT;
   assign diff_neg = -diff_ff;
   assign mag      = diff_ff[DATA_BITS] ? diff_neg[DATA_BITS-1:0] : diff_ff[DATA_BITS-1:0];

   // one restoring step: bring in next dividend bit, try subtract
   assign rem_shift = {rem_ff[REM_W-2:0], quo_ff[NUM_W-1]};
   assign trial     = {1'b0, rem_shift} - {2'b00, den_ff};
   assign quo_ext   = {1'b0, quo_ff};

   assign sts.div_last = (cnt_ff == CNT_W'(1));

   // next values
   always_comb begin
      shift_in = shift_ff;
      diff_in  = diff_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      clk_in   = clk_ff;
      smp_in   = smp_ff;
      raw_in   = raw_ff;
      wgt_in   = wgt_ff;

      if (cmd.shift_clr) begin
         shift_in = '0;
      end else if (cmd.shift_en) begin
         shift_in = {shift_ff[DATA_BITS-2:0], data_line};
      end

      if (cmd.diff_load) begin
         diff_in = {1'b0, code} - {1'b0, zero_offset};
      end

      // divider load and steps
      if (cmd.div_init) begin
         quo_in = NUM_W'(mag) << FRACTION_BITS;
         rem_in = '0;
         den_in = (scale_divisor == '0) ? DEN_W'(1) : scale_divisor;
         cnt_in = CNT_W'(NUM_W);
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff - 1'b1;
         if (!trial[REM_W]) begin
            rem_in = trial[REM_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
      end

      // output word register
      if (cmd.load_tick) begin
         clk_in = cmd.clk_level;
         smp_in = 1'b0;
         raw_in = '0;
         wgt_in = '0;
      end else if (cmd.finish) begin
         clk_in = 1'b0;
         smp_in = 1'b1;
         raw_in = code;
         wgt_in = diff_ff[DATA_BITS] ? -quo_ext : quo_ext;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      diff_ff  <= diff_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      clk_ff   <= clk_in;
      smp_ff   <= smp_in;
      raw_ff   <= raw_in;
      wgt_ff   <= wgt_in;
   end

   assign out_clock_line   = clk_ff;
   assign out_sample_valid = smp_ff;
   assign out_raw_code     = raw_ff;
   assign out_weight_q4    = $signed(wgt_ff);

endmodule

// ===== src/lcadc_checker.sv =====
// port-level assertions for the load cell reader, bound to the top level
`include "assert_macros.svh"

module lcadc_checker #(
   parameter int DATA_BITS = lcadc_pkg::DATA_BITS_DEFAULT
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_clock_line,
   input logic [DATA_BITS-1:0] rsp_raw_code
);

   // an accepted tick either shows a word next cycle or keeps the block busy
   `ASSERT_NEXT(a_accept_answered, clock, reset, req_valid && !req_stall, rsp_valid || req_stall, "accepted tick produced neither word nor busy")

   // no new tick is taken while the output word is held
   `ASSERT_IMPLY(a_hold_blocks_input, clock, reset, rsp_valid && rsp_stall, req_stall, "input taken while output word held")

   // a clock-high word is never followed directly by another clock-high word
   `ASSERT_NEXT(a_no_double_high, clock, reset, rsp_valid && !rsp_stall && rsp_clock_line, !(rsp_valid && rsp_clock_line), "two clock-high ticks in a row")

   // stalled word stays
   `ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_raw_code), "stalled output word changed")

endmodule

bind load_cell_adc_reader lcadc_checker #(
   .DATA_BITS (DATA_BITS)
) u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_clock_line (rsp_clock_line),
   .rsp_raw_code   (rsp_raw_code)
);

// ===== tb/tb_load_cell_adc_reader.sv =====
// self-checking testbench for the load cell converter reader
`timescale 1ns / 1ps

module tb_load_cell_adc_reader;

   localparam int DATA_BITS     = lcadc_pkg::DATA_BITS_DEFAULT;
   localparam int FRACTION_BITS = lcadc_pkg::FRACTION_BITS_DEFAULT;
   localparam int WEIGHT_W      = DATA_BITS + FRACTION_BITS + 1;
   localparam int IDLE_LIMIT    = 1000;
   localparam int READ_PHASES   = 6;

   logic clock;
   logic reset = 1'b1;

   logic                                req_valid     = 1'b0;
   logic                                req_stall;
   logic                                req_data_line = 1'b1;
   logic                                rsp_valid;
   logic                                rsp_stall     = 1'b0;
   logic                                rsp_clock_line;
   logic                                rsp_sample_valid;
   logic [DATA_BITS-1:0]                rsp_raw_code;
   logic signed [WEIGHT_W-1:0]          rsp_weight_q4;
   logic                                csr_psel      = 1'b0;
   logic                                csr_penable   = 1'b0;
   logic                                csr_pwrite    = 1'b0;
   logic [lcadc_pkg::CSR_ADDR_W-1:0]    csr_paddr     = '0;
   logic [lcadc_pkg::CSR_DATA_W-1:0]    csr_pwdata    = '0;
   logic [lcadc_pkg::CSR_DATA_W-1:0]    csr_prdata;
   logic                                csr_pready;

   // tracks the link state and holds the words the block owes
   class reading_tracker;
      typedef enum logic [1:0] {LINK_IDLE, LINK_HIGH, LINK_LOW} link_phase_type;
      typedef struct packed {
         logic                 clk_level;
         logic                 sample_done;
         logic [DATA_BITS-1:0] raw;
         logic [WEIGHT_W-1:0]  weight;
      } tick_word_type;

      logic [DATA_BITS-1:0]        zero_offset;
      logic [lcadc_pkg::DEN_W-1:0] scale;
      link_phase_type              phase;
      int                          pulses;
      logic [DATA_BITS-1:0]        shifter;
      tick_word_type               expected_ticks[$];
      int                          failures;
      int                          reads_done;

      function new();
         zero_offset = DATA_BITS'(lcadc_pkg::ZERO_OFFSET_RESET);
         scale       = lcadc_pkg::DEN_W'(lcadc_pkg::SCALE_RESET);
         phase       = LINK_IDLE;
         pulses      = 0;
         shifter     = '0;
         failures    = 0;
         reads_done  = 0;
      endfunction

      function void set_register(lcadc_pkg::csr_index_type idx,
                                 logic [lcadc_pkg::CSR_DATA_W-1:0] value);
         if (idx == lcadc_pkg::REG_ZERO_OFFSET) begin
            zero_offset = value[DATA_BITS-1:0];
         end else begin
            scale = value[lcadc_pkg::DEN_W-1:0];
         end
      endfunction

      // calibrated weight, truncated toward zero and clamped to the port range
      function logic [WEIGHT_W-1:0] weight_of(logic [DATA_BITS-1:0] raw);
         longint diff;
         longint den;
         longint q;
         diff = longint'(raw) - longint'(zero_offset);
         den  = (scale == 0) ? 1 : longint'(scale);
         q    = (diff * (longint'(1) << FRACTION_BITS)) / den;
         if (q > (longint'(1) << (WEIGHT_W - 1)) - 1) q = (longint'(1) << (WEIGHT_W - 1)) - 1;
         if (q < -(longint'(1) << (WEIGHT_W - 1))) q = -(longint'(1) << (WEIGHT_W - 1));
         return q[WEIGHT_W-1:0];
      endfunction

      // one accepted tick: advance the link and queue its output word
      function void take_tick(logic level);
         tick_word_type w;
         w = '0;
         case (phase)
            LINK_HIGH: begin
               w.clk_level = 1'b1;
               phase = LINK_LOW;
            end
            LINK_LOW: begin
               if (pulses < DATA_BITS) shifter = {shifter[DATA_BITS-2:0], level};
               pulses++;
               if (pulses >= DATA_BITS + 1) begin
                  w.sample_done = 1'b1;
                  w.raw = shifter ^ (DATA_BITS'(1) << (DATA_BITS - 1));
                  w.weight = weight_of(w.raw);
                  phase = LINK_IDLE;
                  pulses = 0;
                  reads_done++;
               end else begin
                  phase = LINK_HIGH;
               end
            end
            default: begin
               phase = LINK_IDLE;
               if (!level) begin
                  phase = LINK_HIGH;
                  pulses = 0;
                  shifter = '0;
               end
            end
         endcase
         expected_ticks.push_back(w);
      endfunction

      function void check_word(logic clk_level, logic sample_done,
                               logic [DATA_BITS-1:0] raw, logic [WEIGHT_W-1:0] weight);
         tick_word_type w;
         if (expected_ticks.size() == 0) begin
            $error("output word with no tick waiting for it");
            failures++;
            return;
         end
         w = expected_ticks.pop_front();
         if (clk_level !== w.clk_level) begin
            $error("clock_line: expected %0d, got %0d", w.clk_level, clk_level);
            failures++;
         end
         if (sample_done !== w.sample_done) begin
            $error("sample_valid: expected %0d, got %0d", w.sample_done, sample_done);
            failures++;
         end
         if (raw !== w.raw) begin
            $error("raw_code: expected %h, got %h", w.raw, raw);
            failures++;
         end
         if (weight !== w.weight) begin
            $error("weight_q4: expected %0d, got %0d", $signed(w.weight), $signed(weight));
            failures++;
         end
      endfunction
   endclass

   reading_tracker board;
   logic           calm = 1'b0;
   int             stall_left = 0;
   int             ticks_sent = 0;
   int             settings_written = 0;

   load_cell_adc_reader dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_line    (req_data_line),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_clock_line   (rsp_clock_line),
      .rsp_sample_valid (rsp_sample_valid),
      .rsp_raw_code     (rsp_raw_code),
      .rsp_weight_q4    (rsp_weight_q4),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // watch both handshakes in one place so order within an edge is fixed
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) board.take_tick(req_data_line);
         if (rsp_valid && !rsp_stall) begin
            board.check_word(rsp_clock_line, rsp_sample_valid, rsp_raw_code, rsp_weight_q4);
         end
      end
   end

   // result side back-pressure
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // ends the run when nothing moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_psel || reset) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   // one tick word, valid held high straight into the next word when no gap
   task automatic send_tick(input logic level);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_line <= level;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ticks_sent++;
   endtask

   // full read: start tick, then 25 pulses, data bits on the low ticks
   task automatic run_read(input logic [DATA_BITS-1:0] bits);
      int p;
      repeat ($urandom_range(0, 3)) send_tick(1'b1);
      send_tick(1'b0);
      for (p = 0; p <= DATA_BITS; p++) begin
         send_tick(1'($urandom));
         send_tick((p < DATA_BITS) ? bits[DATA_BITS-1-p] : 1'($urandom));
      end
   endtask

   // random ticks, then enough data-high ticks to land back in idle
   task automatic run_noise();
      repeat ($urandom_range(10, 40)) send_tick(1'($urandom));
      repeat (2 * DATA_BITS + 3) send_tick(1'b1);
   endtask

   // hold off the sender until every owed word has come back
   task automatic drain_words();
      req_valid <= 1'b0;
      // the last accepted tick is noted at the edge just passed
      @(posedge clock);
      while (board.expected_ticks.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input lcadc_pkg::csr_index_type idx,
                            input logic [lcadc_pkg::CSR_DATA_W-1:0] value);
      logic [lcadc_pkg::CSR_ADDR_W-1:0] addr;
      addr = lcadc_pkg::CSR_ADDR_W'(idx);
      addr = addr << lcadc_pkg::CSR_INDEX_LSB;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.set_register(idx, value);
      settings_written++;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // calibration settings per phase, extremes first
   task automatic apply_setting(input int phase_idx);
      case (phase_idx)
         1: begin
            write_reg(lcadc_pkg::REG_ZERO_OFFSET, 32'h0);
            write_reg(lcadc_pkg::REG_SCALE, 32'd1);
         end
         2: begin
            write_reg(lcadc_pkg::REG_ZERO_OFFSET, 32'hFF_FFFF);
            write_reg(lcadc_pkg::REG_SCALE, 32'd1);
         end
         3: begin
            // zero divisor counts as one
            write_reg(lcadc_pkg::REG_ZERO_OFFSET, 32'h80_0000);
            write_reg(lcadc_pkg::REG_SCALE, 32'd0);
         end
         4: begin
            write_reg(lcadc_pkg::REG_ZERO_OFFSET, {8'h0, 24'($urandom)});
            write_reg(lcadc_pkg::REG_SCALE, 32'd65535);
         end
         default: begin
            write_reg(lcadc_pkg::REG_ZERO_OFFSET, $urandom);
            write_reg(lcadc_pkg::REG_SCALE, {16'($urandom), 16'($urandom_range(1, 65535))});
         end
      endcase
   endtask

   // shifted bit pattern: code extremes, code at the offset, or random
   function automatic logic [DATA_BITS-1:0] pick_bits();
      case ($urandom_range(0, 9))
         0: return 24'h80_0000;
         1: return 24'h7F_FFFF;
         2: return board.zero_offset ^ 24'h80_0000;
         3: return 24'h00_0000;
         4: return 24'hFF_FFFF;
         default: return 24'($urandom);
      endcase
   endfunction

   initial begin
      int phase_idx;
      int n;
      board = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // data high while idle keeps the link waiting with the clock low
      repeat (4) send_tick(1'b1);

      for (phase_idx = 0; phase_idx < READ_PHASES; phase_idx++) begin
         if (phase_idx > 0) begin
            drain_words();
            apply_setting(phase_idx);
         end
         calm = (phase_idx == 1) || ($urandom_range(0, 4) == 0);
         for (n = 0; n < ((phase_idx == 0) ? 2 : 1); n++) begin
            if (phase_idx == 0) run_read((n == 0) ? 24'h80_0000 : 24'h7F_FFFF);
            else run_read(pick_bits());
         end
         if (phase_idx == READ_PHASES - 1) run_noise();
      end
      repeat (3) send_tick(1'b1);

      // wait for the last words, then let the divider settle
      drain_words();
      calm = 1'b1;
      repeat (2 * (DATA_BITS + FRACTION_BITS + 3)) @(posedge clock);
      if (board.expected_ticks.size() != 0) begin
         $error("%0d tick words never came back", board.expected_ticks.size());
         board.failures++;
      end

      $display("%0d ticks sent, %0d full conversion reads checked", ticks_sent, board.reads_done);
      $display("%0d calibration writes incl. offset extremes and a zero divisor",
               settings_written);
      if (board.failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
